// ===== design/pctb_pkg.sv =====
// ----------------------------------------------------------------------------
// pctb_pkg
// shared types and constants for the periodic callback timer bank
// ----------------------------------------------------------------------------
package pctb_pkg;

   localparam int NUM_SLOTS   = 8;
   localparam int MAX_RESULTS = 8;

   localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam int FCNT_W = $clog2(MAX_RESULTS + 1);

   localparam int ID_W   = 8;
   localparam int TIME_W = 24;
   localparam int ELAP_W = 16;
   localparam int USED_W = 4;

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_ADD    = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;

   typedef enum logic [2:0] {
      STAT_FIRED    = 3'd0,
      STAT_NONE     = 3'd1,
      STAT_ADDED    = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_REMOVED  = 3'd4,
      STAT_NOTFOUND = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_WALK,
      S_SEARCH,
      S_SHIFT,
      S_ADD,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [1:0]        command;
      logic [ELAP_W-1:0] elapsed_ms;
      logic [ID_W-1:0]   timer_id;
      logic [TIME_W-1:0] period_ms;
      logic              fire_now;
   } req_word_type;

   typedef struct packed {
      status_type        status;
      logic [ID_W-1:0]   fired_id;
      logic [USED_W-1:0] entries_used;
      logic              last;
   } rsp_word_type;

   typedef struct packed {
      logic       load;
      logic       walk_step;
      logic       idx_inc;
      logic       shift_step;
      logic       remove_done;
      logic       add_write;
      logic       finish;
      status_type fin_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic report_fire;
      logic pend_valid;
      logic out_free;
      logic idx_last;
      logic id_match;
      logic count_zero;
      logic count_full;
   } dp_stat_type;

endpackage

// ===== design/pctb_ctrl.sv =====
// ----------------------------------------------------------------------------
// pctb_ctrl
// sequencer for tick walks, table search, entry shifts and result hand-off
// ----------------------------------------------------------------------------
module pctb_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  pctb_pkg::req_word_type req_word,
   input  pctb_pkg::dp_stat_type  stat,
   output logic                   req_ready,
   output pctb_pkg::ctl_cmd_type  cmd
);

   pctb_pkg::state_type  state_ff, state_in;
   pctb_pkg::status_type fin_ff, fin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pctb_pkg::S_IDLE;
         fin_ff   <= pctb_pkg::STAT_NONE;
      end else begin
         state_ff <= state_in;
         fin_ff   <= fin_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      fin_in         = fin_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.fin_status = fin_ff;
      unique case (state_ff)
         pctb_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               fin_in   = pctb_pkg::STAT_NONE;
               priority if (req_word.command == pctb_pkg::CMD_TICK) begin
                  if (req_word.elapsed_ms != '0 && !stat.count_zero) begin
                     state_in = pctb_pkg::S_WALK;
                  end else begin
                     state_in = pctb_pkg::S_FINISH;
                  end
               end else if (req_word.command == pctb_pkg::CMD_ADD) begin
                  state_in = pctb_pkg::S_ADD;
               end else if (req_word.command == pctb_pkg::CMD_REMOVE) begin
                  if (stat.count_zero) begin
                     fin_in   = pctb_pkg::STAT_NOTFOUND;
                     state_in = pctb_pkg::S_FINISH;
                  end else begin
                     state_in = pctb_pkg::S_SEARCH;
                  end
               end else begin
                  state_in = pctb_pkg::S_FINISH;
               end
            end
         end
         pctb_pkg::S_WALK: begin
            if (!(stat.report_fire && stat.pend_valid && !stat.out_free)) begin
               cmd.walk_step = 1'b1;
               if (stat.idx_last) begin
                  state_in = pctb_pkg::S_FINISH;
               end
            end
         end
         pctb_pkg::S_SEARCH: begin
            priority if (stat.id_match) begin
               state_in = pctb_pkg::S_SHIFT;
            end else if (stat.idx_last) begin
               fin_in   = pctb_pkg::STAT_NOTFOUND;
               state_in = pctb_pkg::S_FINISH;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         pctb_pkg::S_SHIFT: begin
            if (stat.idx_last) begin
               cmd.remove_done = 1'b1;
               fin_in          = pctb_pkg::STAT_REMOVED;
               state_in        = pctb_pkg::S_FINISH;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         pctb_pkg::S_ADD: begin
            if (stat.count_full) begin
               fin_in = pctb_pkg::STAT_FULL;
            end else begin
               cmd.add_write = 1'b1;
               fin_in        = pctb_pkg::STAT_ADDED;
            end
            state_in = pctb_pkg::S_FINISH;
         end
         pctb_pkg::S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = pctb_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pctb_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== design/pctb_dp.sv =====
// ----------------------------------------------------------------------------
// pctb_dp
// timer table, walk index, pending fired id and result register
// ----------------------------------------------------------------------------
module pctb_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  pctb_pkg::req_word_type req_word,
   input  pctb_pkg::ctl_cmd_type  cmd,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output pctb_pkg::rsp_word_type rsp_word,
   output pctb_pkg::dp_stat_type  stat
);

   logic [pctb_pkg::ID_W-1:0]   id_ff     [pctb_pkg::NUM_SLOTS];
   logic [pctb_pkg::TIME_W-1:0] period_ff [pctb_pkg::NUM_SLOTS];
   logic [pctb_pkg::TIME_W-1:0] remain_ff [pctb_pkg::NUM_SLOTS];

   logic [pctb_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [pctb_pkg::SLOT_W-1:0] idx_ff, idx_in;
   logic [pctb_pkg::FCNT_W-1:0] fcnt_ff, fcnt_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic [pctb_pkg::ID_W-1:0]   pend_id_ff, pend_id_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   pctb_pkg::rsp_word_type      rsp_ff, rsp_in;
   pctb_pkg::req_word_type      req_ff;

   logic [pctb_pkg::CNT_W-1:0]  rd_sum;
   logic [pctb_pkg::SLOT_W-1:0] rd_idx;
   logic [pctb_pkg::SLOT_W-1:0] wr_add_idx;
   logic [pctb_pkg::ID_W-1:0]   rd_id;
   logic [pctb_pkg::TIME_W-1:0] rd_period;
   logic [pctb_pkg::TIME_W-1:0] rd_remain;
   logic [pctb_pkg::TIME_W-1:0] elapsed_ext;
   logic                        fire;
   logic                        push_mid;
   logic [pctb_pkg::USED_W-1:0] used;

   // read port: current entry, or the one above it while shifting down
   always_comb begin
      rd_sum = pctb_pkg::CNT_W'(idx_ff) + pctb_pkg::CNT_W'(cmd.shift_step);
      rd_idx = (rd_sum < pctb_pkg::CNT_W'(pctb_pkg::NUM_SLOTS)) ?
               rd_sum[pctb_pkg::SLOT_W-1:0] : '0;
   end

   assign rd_id       = id_ff[rd_idx];
   assign rd_period   = period_ff[rd_idx];
   assign rd_remain   = remain_ff[rd_idx];
   assign wr_add_idx  = count_ff[pctb_pkg::SLOT_W-1:0];
   assign elapsed_ext = pctb_pkg::TIME_W'(req_ff.elapsed_ms);
   assign fire        = (rd_period != '0) && (rd_remain <= elapsed_ext);
   assign used        = pctb_pkg::USED_W'(count_ff);

   assign stat.report_fire = fire && (fcnt_ff < pctb_pkg::FCNT_W'(pctb_pkg::MAX_RESULTS));
   assign stat.pend_valid  = pend_valid_ff;
   assign stat.out_free    = !rsp_valid_ff || rsp_ready;
   assign stat.idx_last    = (pctb_pkg::CNT_W'(idx_ff) + pctb_pkg::CNT_W'(1)) == count_ff;
   assign stat.id_match    = (rd_id == req_ff.timer_id);
   assign stat.count_zero  = (count_ff == '0);
   assign stat.count_full  = (count_ff >= pctb_pkg::CNT_W'(pctb_pkg::NUM_SLOTS));

   assign push_mid = cmd.walk_step && stat.report_fire && pend_valid_ff;

   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      fcnt_in       = fcnt_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.load) begin
         idx_in        = '0;
         fcnt_in       = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.walk_step) begin
         idx_in = idx_ff + pctb_pkg::SLOT_W'(1);
         if (stat.report_fire) begin
            fcnt_in       = fcnt_ff + pctb_pkg::FCNT_W'(1);
            pend_valid_in = 1'b1;
            pend_id_in    = rd_id;
         end
      end
      if (cmd.idx_inc || cmd.shift_step) begin
         idx_in = idx_ff + pctb_pkg::SLOT_W'(1);
      end
      if (cmd.add_write) begin
         count_in = count_ff + pctb_pkg::CNT_W'(1);
      end
      if (cmd.remove_done) begin
         count_in = count_ff - pctb_pkg::CNT_W'(1);
      end

      if (push_mid) begin
         rsp_valid_in        = 1'b1;
         rsp_in.status       = pctb_pkg::STAT_FIRED;
         rsp_in.fired_id     = pend_id_ff;
         rsp_in.entries_used = used;
         rsp_in.last         = 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_in        = 1'b1;
         rsp_in.entries_used = used;
         rsp_in.last         = 1'b1;
         if (pend_valid_ff) begin
            rsp_in.status   = pctb_pkg::STAT_FIRED;
            rsp_in.fired_id = pend_id_ff;
         end else begin
            rsp_in.status   = cmd.fin_status;
            rsp_in.fired_id = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         idx_ff        <= '0;
         fcnt_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         fcnt_ff       <= fcnt_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_id_ff <= pend_id_in;
      rsp_ff     <= rsp_in;
      if (cmd.load) begin
         req_ff <= req_word;
      end
   end

   // table storage
   always_ff @(posedge clock) begin
      if (cmd.walk_step && rd_period != '0) begin
         remain_ff[rd_idx] <= fire ? rd_period : (rd_remain - elapsed_ext);
      end
      if (cmd.shift_step) begin
         id_ff[idx_ff]     <= rd_id;
         period_ff[idx_ff] <= rd_period;
         remain_ff[idx_ff] <= rd_remain;
      end
      if (cmd.add_write) begin
         id_ff[wr_add_idx]     <= req_ff.timer_id;
         period_ff[wr_add_idx] <= req_ff.period_ms;
         remain_ff[wr_add_idx] <= req_ff.fire_now ? '0 : req_ff.period_ms;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

// ===== design/periodic_callback_timer_bank_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_callback_timer_bank_unit
// table of periodic timers kept packed in insertion order
// ----------------------------------------------------------------------------
// One command word is taken at a time; the next is accepted once the last
// result word of the current one is in the output register, even if that
// word has not been taken yet. The table is walked one entry per cycle
// through a single read port, holding while a fired id waits on a full
// output register. A tick with a nonzero elapsed time on a non-empty table
// walks every entry in use; other ticks skip the walk. A remove searches for
// the id and shifts each later entry down by one, or stops at the last entry
// if the id is absent. Result words wait on rsp_ready while the output
// register is full. A tick gives one word per fired timer in table order,
// or a single "none fired" word; other commands give one word.
module periodic_callback_timer_bank_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  pctb_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output pctb_pkg::rsp_word_type rsp_word
);

   pctb_pkg::ctl_cmd_type cmd;
   pctb_pkg::dp_stat_type stat;

   pctb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_word  (req_word),
      .stat      (stat),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   pctb_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .cmd       (cmd),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_word  (rsp_word),
      .stat      (stat)
   );

endmodule

// ===== design/pctb_checker.sv =====
// ----------------------------------------------------------------------------
// pctb_checker
// port-level checks for the periodic callback timer bank
// ----------------------------------------------------------------------------
module pctb_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input pctb_pkg::rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != pctb_pkg::STAT_FIRED |-> rsp_word.fired_id == '0)
      else $error("fired id set on a word that is not a firing");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.status != pctb_pkg::STAT_FIRED |-> rsp_word.last)
      else $error("non-firing word not marked last");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second command word taken while one is in progress");

endmodule

bind periodic_callback_timer_bank_unit pctb_checker u_pctb_checker (.*);

// ===== test/tb_periodic_callback_timer_bank_unit.sv =====
// ----------------------------------------------------------------------------
// tb_periodic_callback_timer_bank_unit
// self-checking bench for the periodic callback timer bank
// ----------------------------------------------------------------------------
// A short table of directed command words covers the empty table, the full
// table, zero periods, zero and maximum elapsed times, duplicate ids, absent
// ids and the reserved command. Random command words follow, mostly well
// formed adds, ticks and removes of live ids. Every result word is compared
// with a timer table model kept in the bench, while both sides of the block
// see random gaps and stalls.
module tb_periodic_callback_timer_bank_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import pctb_pkg::*;

   localparam logic [1:0] CMD_RESERVED = 2'd3;
   localparam int RANDOM_WORDS = 400;
   localparam int NUM_ROWS     = 25;
   localparam int DRAIN_CYCLES = 24;
   localparam int CYCLE_LIMIT  = 600000;

   typedef struct packed {
      req_word_type      req;
      logic              typed;
      status_type        status;
      logic [USED_W-1:0] used;
   } dir_row_type;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   logic [ID_W-1:0]   tbl_id     [NUM_SLOTS];
   logic [TIME_W-1:0] tbl_period [NUM_SLOTS];
   logic [TIME_W-1:0] tbl_left   [NUM_SLOTS];
   int                tbl_count  = 0;

   rsp_word_type due_words [$];

   int          errors      = 0;
   int          words_sent  = 0;
   int          words_seen  = 0;
   int          fired_seen  = 0;
   int          full_seen   = 0;
   int          absent_seen = 0;
   int          stall_left  = 0;
   int unsigned cycles      = 0;
   bit          calm        = 1'b0;

   periodic_callback_timer_bank_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[periodic_callback_timer_bank_unit] ERROR");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic rsp_word_type word_of(status_type st, logic [ID_W-1:0] id,
                                            logic is_last);
      rsp_word_type w;
      w.status       = st;
      w.fired_id     = id;
      w.entries_used = tbl_count[USED_W-1:0];
      w.last         = is_last;
      return w;
   endfunction

   // applies one command word to the timer table and queues its result words
   function automatic void advance_timers(input req_word_type w);
      status_type      st  [MAX_RESULTS];
      logic [ID_W-1:0] ids [MAX_RESULTS];
      int n, hit;
      n   = 0;
      hit = -1;
      case (w.command)
         CMD_TICK: begin
            if (w.elapsed_ms != '0) begin
               for (int i = 0; i < tbl_count; i++) begin
                  if (tbl_period[i] != '0) begin
                     if (tbl_left[i] > {8'h00, w.elapsed_ms}) begin
                        tbl_left[i] = tbl_left[i] - {8'h00, w.elapsed_ms};
                     end else begin
                        tbl_left[i] = tbl_period[i];
                        if (n < MAX_RESULTS) begin
                           st[n]  = STAT_FIRED;
                           ids[n] = tbl_id[i];
                           n++;
                        end
                     end
                  end
               end
            end
            if (n == 0) begin
               st[0]  = STAT_NONE;
               ids[0] = '0;
               n      = 1;
            end
         end
         CMD_ADD: begin
            if (tbl_count >= NUM_SLOTS) begin
               st[0] = STAT_FULL;
            end else begin
               tbl_id[tbl_count]     = w.timer_id;
               tbl_period[tbl_count] = w.period_ms;
               tbl_left[tbl_count]   = w.fire_now ? '0 : w.period_ms;
               tbl_count++;
               st[0] = STAT_ADDED;
            end
            ids[0] = '0;
            n      = 1;
         end
         CMD_REMOVE: begin
            for (int i = 0; i < tbl_count; i++) begin
               if (hit < 0 && tbl_id[i] == w.timer_id) hit = i;
            end
            if (hit < 0) begin
               st[0] = STAT_NOTFOUND;
            end else begin
               for (int i = hit; i < tbl_count - 1; i++) begin
                  tbl_id[i]     = tbl_id[i + 1];
                  tbl_period[i] = tbl_period[i + 1];
                  tbl_left[i]   = tbl_left[i + 1];
               end
               tbl_count--;
               st[0] = STAT_REMOVED;
            end
            ids[0] = '0;
            n      = 1;
         end
         default: begin
            st[0]  = STAT_NONE;
            ids[0] = '0;
            n      = 1;
         end
      endcase
      for (int k = 0; k < n; k++) begin
         due_words.insert(due_words.size(), word_of(st[k], ids[k], k == n - 1));
      end
   endfunction

   function automatic dir_row_type dir_row(logic [1:0] cmd, int unsigned elapsed,
                                           int unsigned id, int unsigned period, bit now,
                                           bit typed, status_type st, int unsigned used);
      dir_row_type r;
      r.req.command    = cmd;
      r.req.elapsed_ms = elapsed[ELAP_W-1:0];
      r.req.timer_id   = id[ID_W-1:0];
      r.req.period_ms  = period[TIME_W-1:0];
      r.req.fire_now   = now;
      r.typed          = typed;
      r.status         = st;
      r.used           = used[USED_W-1:0];
      return r;
   endfunction

   function automatic req_word_type random_command();
      req_word_type w;
      logic [31:0]  rnd;
      int           pick;
      rnd          = $urandom;
      w.elapsed_ms = rnd[15:0];
      w.timer_id   = rnd[23:16];
      w.fire_now   = rnd[24];
      rnd          = $urandom;
      w.period_ms  = rnd[23:0];
      pick         = $urandom_range(0, 99);
      if (pick >= 45 && pick < 75 && tbl_count >= 6 && $urandom_range(0, 1) == 1) pick = 80;
      if (pick < 2) begin
         w.command = CMD_RESERVED;
      end else if (pick < 45) begin
         w.command = CMD_TICK;
         pick = $urandom_range(0, 9);
         if (pick < 6) w.elapsed_ms = ELAP_W'($urandom_range(1, 12));
         else if (pick < 7) w.elapsed_ms = '0;
         else if (pick < 9) w.elapsed_ms = ELAP_W'($urandom_range(13, 300));
      end else if (pick < 75) begin
         w.command = CMD_ADD;
         if ($urandom_range(0, 9) < 7) w.timer_id = ID_W'($urandom_range(0, 15));
         pick = $urandom_range(0, 9);
         if (pick < 7) w.period_ms = TIME_W'($urandom_range(1, 40));
         else if (pick < 8) w.period_ms = '0;
         else if (pick < 9) w.period_ms = TIME_W'($urandom_range(41, 2000));
      end else begin
         w.command = CMD_REMOVE;
         if (tbl_count > 0 && $urandom_range(0, 3) != 0) begin
            w.timer_id = tbl_id[$urandom_range(0, tbl_count - 1)];
         end else if ($urandom_range(0, 1) == 1) begin
            w.timer_id = ID_W'($urandom_range(0, 15));
         end
      end
      return w;
   endfunction

   task automatic send_word(input req_word_type w);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_timers(w);
   endtask

   task automatic hold_off(input bit drain);
      int gap;
      gap = pick_gap();
      if (drain) begin
         req_valid <= 1'b0;
         do @(posedge clock); while (due_words.size() != 0);
      end else if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : rsp_stall
      int stall_len;
      if (stall_left != 0) begin
         rsp_ready  <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         stall_len = pick_gap();
         rsp_ready <= (stall_len == 0);
         if (stall_len != 0) stall_left <= stall_len - 1;
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         words_seen++;
         if (due_words.size() == 0) begin
            errors++;
            $display("%0t unexpected result word: expected none, actual %h", $time, rsp_word);
         end else begin
            want = due_words.pop_front();
            check_field("status", want.status, rsp_word.status);
            check_field("fired_id", want.fired_id, rsp_word.fired_id);
            check_field("entries_used", want.entries_used, rsp_word.entries_used);
            check_field("last", want.last, rsp_word.last);
            if (want.status == STAT_FIRED) fired_seen++;
            if (want.status == STAT_FULL) full_seen++;
            if (want.status == STAT_NOTFOUND) absent_seen++;
         end
      end
   end

   initial begin : stimulus
      dir_row_type  rows [NUM_ROWS];
      rsp_word_type typed_word;
      req_word_type w;
      int           sent;
      rows[0]  = dir_row(CMD_TICK, 5, 'h00, 0, 0, 1, STAT_NONE, 0);
      rows[1]  = dir_row(CMD_REMOVE, 0, 'h07, 0, 0, 1, STAT_NOTFOUND, 0);
      rows[2]  = dir_row(CMD_RESERVED, 'hFFFF, 'hFF, 'hFFFFFF, 1, 1, STAT_NONE, 0);
      rows[3]  = dir_row(CMD_ADD, 0, 'h00, 0, 0, 1, STAT_ADDED, 1);
      rows[4]  = dir_row(CMD_ADD, 0, 'hFF, 'hFFFFFF, 0, 1, STAT_ADDED, 2);
      rows[5]  = dir_row(CMD_ADD, 0, 'h11, 1, 1, 1, STAT_ADDED, 3);
      rows[6]  = dir_row(CMD_ADD, 0, 'h22, 10, 1, 1, STAT_ADDED, 4);
      rows[7]  = dir_row(CMD_TICK, 0, 'h00, 0, 0, 1, STAT_NONE, 4);
      rows[8]  = dir_row(CMD_TICK, 'hFFFF, 'h00, 0, 0, 0, STAT_NONE, 0);
      rows[9]  = dir_row(CMD_ADD, 0, 'h22, 3, 1, 1, STAT_ADDED, 5);
      rows[10] = dir_row(CMD_ADD, 0, 'h33, 2, 1, 1, STAT_ADDED, 6);
      rows[11] = dir_row(CMD_ADD, 0, 'h44, 5, 0, 1, STAT_ADDED, 7);
      rows[12] = dir_row(CMD_ADD, 0, 'h55, 1, 1, 1, STAT_ADDED, 8);
      rows[13] = dir_row(CMD_ADD, 0, 'h66, 7, 1, 1, STAT_FULL, 8);
      rows[14] = dir_row(CMD_TICK, 1, 'h00, 0, 0, 0, STAT_NONE, 0);
      rows[15] = dir_row(CMD_TICK, 'hFFFF, 'h00, 0, 0, 0, STAT_NONE, 0);
      rows[16] = dir_row(CMD_REMOVE, 0, 'h22, 0, 0, 1, STAT_REMOVED, 7);
      rows[17] = dir_row(CMD_REMOVE, 0, 'h99, 0, 0, 1, STAT_NOTFOUND, 7);
      rows[18] = dir_row(CMD_REMOVE, 0, 'h00, 0, 0, 1, STAT_REMOVED, 6);
      rows[19] = dir_row(CMD_REMOVE, 0, 'h55, 0, 0, 1, STAT_REMOVED, 5);
      rows[20] = dir_row(CMD_TICK, 3, 'h00, 0, 0, 0, STAT_NONE, 0);
      rows[21] = dir_row(CMD_ADD, 0, 'hAA, 'hAAAAAA, 0, 1, STAT_ADDED, 6);
      rows[22] = dir_row(CMD_ADD, 0, 'h55, 'h555555, 1, 1, STAT_ADDED, 7);
      rows[23] = dir_row(CMD_TICK, 'hAAAA, 'h00, 0, 0, 0, STAT_NONE, 0);
      rows[24] = dir_row(CMD_TICK, 'h5555, 'h00, 0, 0, 0, STAT_NONE, 0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int k = 0; k < NUM_ROWS; k++) begin
         send_word(rows[k].req);
         if (rows[k].typed) begin
            typed_word              = word_of(rows[k].status, '0, 1'b1);
            typed_word.entries_used = rows[k].used;
            void'(due_words.pop_back());
            due_words.insert(due_words.size(), typed_word);
         end
         words_sent++;
         hold_off(k == NUM_ROWS - 1);
      end

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         if (sent % 60 == 0) calm = ($urandom_range(0, 3) == 0);
         w = random_command();
         send_word(w);
         words_sent++;
         if (w.command != CMD_RESERVED) sent++;
         if (sent < RANDOM_WORDS) hold_off(sent == RANDOM_WORDS / 2 || $urandom_range(0, 99) == 0);
      end
      req_valid <= 1'b0;

      while (due_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run sent %0d command words and checked %0d result words", words_sent, words_seen);
      $display("timers fired %0d times, %0d adds hit a full table, %0d removes missed",
               fired_seen, full_seen, absent_seen);
      if (errors == 0) begin
         $display("[periodic_callback_timer_bank_unit] OK");
      end else begin
         $display("[periodic_callback_timer_bank_unit] ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/pctb_pkg.sv
design/pctb_ctrl.sv
design/pctb_dp.sv
design/periodic_callback_timer_bank_unit.sv
design/pctb_checker.sv
test/tb_periodic_callback_timer_bank_unit.sv
